>>> rtl/core/psvm_pkg.sv
// psvm_pkg: shared types and codes for the sample voice mixer
// no dependencies
`default_nettype none
package psvm_pkg;
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_LENGTH  = 2'd1;
    localparam logic [1:0] ACT_TRIGGER = 2'd2;
    localparam logic [1:0] ACT_TICK    = 2'd3;

    localparam logic [0:0] REG_MIX_GAIN   = 1'd0;
    localparam logic [0:0] REG_CLIP_LEVEL = 1'd1;

    localparam logic [14:0] MIX_GAIN_RESET   = 15'd22938;
    localparam logic [14:0] CLIP_LEVEL_RESET = 15'd26214;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         pad;
        logic [14:0]        frame_index;
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
        logic [15:0]        pad_frames;
        logic [15:0]        pitch_rate;
        logic signed [15:0] mix_in_left;
        logic signed [15:0] mix_in_right;
        logic               block_end;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic [4:0]         active_voices;
        logic               last_frame;
    } out_item_t;
endpackage
`default_nettype wire

>>> rtl/core/polyphonic_sample_voice_mixer.sv
// polyphonic_sample_voice_mixer: stereo sample playback and mixing engine
// depends on psvm_pkg and psvm_ram
//
// Requests enter on in_valid/in_stall with an in_item_t payload; results
// leave on out_valid/out_stall as out_item_t, one per tick request only.
// Load, length and trigger requests are taken back to back.
// A tick walks every voice slot through the sample memory: a playing voice
// reads frame i, reads frame i+1 and accumulates; an idle or finishing slot
// skips the second read. Gain, mix-in and clip steps follow the walk.
// No request is taken meanwhile; the walk uses the single sample ram port.
// Voice active flags and pad lengths are flip-flops cleared at reset, so no
// clearing pass is needed; the sample store holds garbage until loaded.
// A finished result sits in an output register; the block takes the next
// request while it waits, and only stalls a new tick until it is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken any cycle.
`default_nettype none
module polyphonic_sample_voice_mixer
    import psvm_pkg::*;
#(
    parameter int PAD_COUNT      = 16,
    parameter int VOICE_COUNT    = 16,
    parameter int FRAMES_PER_PAD = 32768
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_item,
    input  wire logic      cfg_we,
    input  wire logic      cfg_index,
    input  wire logic [14:0] cfg_data
);
    localparam int PW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int FW = $clog2(FRAMES_PER_PAD);
    localparam int LW = FW + 1;
    localparam int AW = PW + FW;
    // one spare frame bit so a fast voice past the end does not wrap
    localparam int PSW = FW + 13;
    localparam int SW = 34 + VW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RDA  = 3'd1;
    localparam logic [2:0] ST_RDB  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [14:0] gain_reg, clip_reg;
    logic [LW-1:0] len_reg [PAD_COUNT];
    logic         act_reg [VOICE_COUNT];
    logic [PW-1:0] vpad_reg [VOICE_COUNT];
    logic [15:0]   rate_reg [VOICE_COUNT];
    logic [PSW-1:0] pos_reg [VOICE_COUNT];
    logic [VW-1:0] slot_reg, vi_reg;
    in_item_t req_reg;
    logic signed [SW-1:0] suml_reg, sumr_reg;
    logic [5:0] cnt_reg;
    logic [31:0] a_reg;
    logic signed [SW+15:0] tl_reg, tr_reg;
    logic out_valid_reg;
    out_item_t out_reg;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0] ram_wdata, ram_rdata;

    psvm_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_samples (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    logic accept;
    logic [PW-1:0] cur_pad;
    logic [FW:0] cur_idx;
    logic cur_live;
    logic [11:0] frac;

    assign in_stall = (state_reg != ST_IDLE) ||
                      (in_item.action == ACT_TICK && out_valid_reg);
    assign accept = in_valid && !in_stall;
    assign cur_pad = vpad_reg[vi_reg];
    assign cur_idx = pos_reg[vi_reg][PSW-1:12];
    assign frac = pos_reg[vi_reg][11:0];
    assign cur_live = act_reg[vi_reg] &&
        (({1'b0, cur_idx} + (FW+2)'(1)) < {1'b0, len_reg[cur_pad]});

    always_comb
    begin
        ram_we = 1'b0;
        ram_wdata = {in_item.sample_right, in_item.sample_left};
        ram_addr = AW'({cur_pad, cur_idx[FW-1:0]});
        if (state_reg == ST_RDB)
            ram_addr = AW'({cur_pad, cur_idx[FW-1:0]} + 1);
        if (accept && in_item.action == ACT_LOAD &&
            32'(in_item.pad) < PAD_COUNT && 32'(in_item.frame_index) < FRAMES_PER_PAD)
        begin
            ram_we = 1'b1;
            ram_addr = AW'({in_item.pad[PW-1:0], in_item.frame_index[FW-1:0]});
        end
    end

    function automatic logic signed [15:0] finish(input logic signed [SW+15:0] t,
                                                  input logic [14:0] clip);
        logic signed [SW+15:0] r;
        r = (t + (SW+16)'(64'sd1 <<< 26)) >>> 27;
        if (r > $signed({1'b0, clip}))
            return $signed({1'b0, clip});
        if (r < -$signed({1'b0, clip}))
            return -$signed({1'b0, clip});
        return r[15:0];
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && in_item.action == ACT_TICK) state_next = ST_RDA;
            ST_RDA:  state_next = cur_live ? ST_RDB : ST_ACC;
            ST_RDB:  state_next = ST_ACC;
            ST_ACC:  state_next = (32'(vi_reg) == VOICE_COUNT - 1) ? ST_MUL : ST_RDA;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            gain_reg <= MIX_GAIN_RESET;
            clip_reg <= CLIP_LEVEL_RESET;
            slot_reg <= '0;
            vi_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PAD_COUNT; i++) len_reg[i] <= '0;
            for (int i = 0; i < VOICE_COUNT; i++) act_reg[i] <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_MIX_GAIN) gain_reg <= cfg_data;
                else clip_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
            if (accept)
            begin
                req_reg <= in_item;
                if (in_item.action == ACT_LENGTH && 32'(in_item.pad) < PAD_COUNT)
                    len_reg[in_item.pad[PW-1:0]] <=
                        (32'(in_item.pad_frames) > FRAMES_PER_PAD) ? LW'(FRAMES_PER_PAD)
                                                                 : LW'(in_item.pad_frames);
                if (in_item.action == ACT_TRIGGER)
                begin
                    // clamp the pad, skip empty pads
                    logic [PW-1:0] tp;
                    tp = (32'(in_item.pad) > PAD_COUNT - 1) ? PW'(PAD_COUNT - 1)
                                                           : in_item.pad[PW-1:0];
                    if (len_reg[tp] != '0)
                    begin
                        act_reg[slot_reg] <= 1'b1;
                        vpad_reg[slot_reg] <= tp;
                        rate_reg[slot_reg] <= in_item.pitch_rate;
                        pos_reg[slot_reg] <= '0;
                        slot_reg <= (32'(slot_reg) == VOICE_COUNT - 1) ? '0 : slot_reg + 1'b1;
                    end
                end
                if (in_item.action == ACT_TICK)
                begin
                    vi_reg <= '0;
                    suml_reg <= '0;
                    sumr_reg <= '0;
                    cnt_reg <= '0;
                end
            end
            unique case (state_reg)
                ST_RDA:
                    if (!cur_live) act_reg[vi_reg] <= 1'b0;
                ST_RDB:
                    a_reg <= ram_rdata;
                ST_ACC:
                begin
                    if (act_reg[vi_reg])
                    begin
                        // b frame is on the ram output now
                        suml_reg <= suml_reg
                            + SW'($signed(a_reg[15:0]) * $signed({1'b0, 13'd4096 - 13'(frac)}))
                            + SW'($signed(ram_rdata[15:0]) * $signed({1'b0, frac}));
                        sumr_reg <= sumr_reg
                            + SW'($signed(a_reg[31:16]) * $signed({1'b0, 13'd4096 - 13'(frac)}))
                            + SW'($signed(ram_rdata[31:16]) * $signed({1'b0, frac}));
                        pos_reg[vi_reg] <= pos_reg[vi_reg] + PSW'(rate_reg[vi_reg]);
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (32'(vi_reg) != VOICE_COUNT - 1) vi_reg <= vi_reg + 1'b1;
                end
                ST_MUL:
                begin
                    tl_reg <= (SW+16)'(suml_reg * $signed({1'b0, gain_reg}));
                    tr_reg <= (SW+16)'(sumr_reg * $signed({1'b0, gain_reg}));
                end
                ST_FIN:
                begin
                    tl_reg <= tl_reg + ((SW+16)'(req_reg.mix_in_left) <<< 27);
                    tr_reg <= tr_reg + ((SW+16)'(req_reg.mix_in_right) <<< 27);
                end
                ST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    out_reg.out_left <= finish(tl_reg, clip_reg);
                    out_reg.out_right <= finish(tr_reg, clip_reg);
                    out_reg.active_voices <= (cnt_reg > 6'd31) ? 5'd31 : cnt_reg[4:0];
                    out_reg.last_frame <= req_reg.block_end;
                end
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_reg;
endmodule
`default_nettype wire

>>> rtl/core/psvm_ram.sv
// psvm_ram: generic single port synchronous ram with registered read
// no dependencies
`default_nettype none
module psvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> rtl/core/psvm_checker.sv
// psvm_checker: port level assertions for the voice mixer
// depends on psvm_pkg; bound to polyphonic_sample_voice_mixer
`default_nettype none
module psvm_checker
    import psvm_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_item_t  in_item,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_item
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");
    a_clip_sym: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.out_left != 16'sh8000 && out_item.out_right != 16'sh8000)
        else $error("output beyond symmetric clip");
    a_tick_waits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_item.action == ACT_TICK && out_valid && out_stall |-> in_stall)
        else $error("tick accepted while result blocked");
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_item.action == ACT_TICK |=> !$rose(out_valid))
        else $error("result too soon");
endmodule

bind polyphonic_sample_voice_mixer psvm_checker u_psvm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
);
`default_nettype wire
